[design/usd_pkg.sv]
// Shared types, constants and helpers for the UTF-8 stream decoder.
`default_nettype none
package usd_pkg;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Reset value of the invalid code register (U+FFFD)
  localparam logic [31:0] INVALID_CODE_RST = 32'h0000_FFFD;

  // Lead byte classes
  localparam logic [2:0] LEN_BAD   = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  // Result item
  typedef struct packed {
    logic [31:0] code_point;
    logic        is_invalid;
    logic        last_of_run;
    logic        text_done;
  } out_t;

  // Command from front to back: n_inv invalid results, then an optional
  // good code point
  typedef struct packed {
    logic [2:0]  n_inv;
    logic        has_good;
    logic [20:0] cp;
    logic        fin;
  } cmd_t;

  // Sequence length announced by a lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0)             len = LEN_ASCII;
    else if (b[7:5] == 3'b110)    len = LEN_TWO;
    else if (b[7:4] == 4'b1110)   len = LEN_THREE;
    else if (b[7:3] == 5'b11110)  len = LEN_FOUR;
    else                          len = LEN_BAD;
    return len;
  endfunction

  // Payload bits of a lead byte, zero extended
  function automatic logic [14:0] lead_bits(input logic [7:0] b, input logic [2:0] len);
    logic [14:0] v;
    case (len)
      LEN_TWO:   v = {10'd0, b[4:0]};
      LEN_THREE: v = {11'd0, b[3:0]};
      default:   v = {12'd0, b[2:0]};
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[design/usd_front.sv]
// Front end: accepts bytes, tracks the pending sequence, issues commands.
`default_nettype none
module usd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire usd_pkg::in_t in_data,
  input  wire logic         q_full,
  output logic              in_stall,
  output logic              q_push,
  output usd_pkg::cmd_t     q_cmd
);

  logic [1:0]  cnt_r, cnt_nxt;    // buffered bytes, 0 when idle
  logic [2:0]  len_r, len_nxt;    // announced length, 0 when idle
  logic [14:0] acc_r, acc_nxt;    // partial code point
  logic        take;
  logic        fresh;
  logic [2:0]  flen;
  logic [7:0]  b;
  logic        fin;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign b        = in_data.data_byte;
  assign fin      = in_data.final_byte;
  assign flen     = usd_pkg::lead_length(b);

  // Classify the byte against the pending sequence
  always_comb begin
    q_cmd          = '0;
    q_cmd.fin      = fin;
    cnt_nxt        = cnt_r;
    len_nxt        = len_r;
    acc_nxt        = acc_r;
    fresh          = 1'b0;
    if (cnt_r == 2'd0) begin
      fresh = 1'b1;
    end else if (b[7:6] == 2'b10) begin
      if ({1'b0, cnt_r} + 3'd1 == len_r) begin
        q_cmd.has_good = 1'b1;
        q_cmd.cp       = {acc_r, b[5:0]};
        cnt_nxt        = 2'd0;
        len_nxt        = 3'd0;
      end else if (fin) begin
        q_cmd.n_inv = {1'b0, cnt_r} + 3'd1;
        cnt_nxt     = 2'd0;
        len_nxt     = 3'd0;
      end else begin
        acc_nxt = {acc_r[8:0], b[5:0]};
        cnt_nxt = cnt_r + 2'd1;
      end
    end else begin
      // broken sequence: flush buffered bytes, then decode as a lead
      q_cmd.n_inv = {1'b0, cnt_r};
      cnt_nxt     = 2'd0;
      len_nxt     = 3'd0;
      fresh       = 1'b1;
    end

    if (fresh) begin
      if (flen == usd_pkg::LEN_ASCII) begin
        q_cmd.has_good = 1'b1;
        q_cmd.cp       = {13'd0, b};
      end else if (flen == usd_pkg::LEN_BAD || fin) begin
        q_cmd.n_inv = q_cmd.n_inv + 3'd1;
      end else begin
        acc_nxt = usd_pkg::lead_bits(b, flen);
        cnt_nxt = 2'd1;
        len_nxt = flen;
      end
    end

    if (fin) begin
      cnt_nxt = 2'd0;
      len_nxt = 3'd0;
    end
  end

  assign q_push = take && (q_cmd.n_inv != 3'd0 || q_cmd.has_good);

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      len_r <= 3'd0;
    end else if (take) begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

  // Partial code point, payload only
  always_ff @(posedge clk) begin
    if (take) begin
      acc_r <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

[design/usd_queue.sv]
// Command queue between the front and the back.
`default_nettype none
module usd_queue #(
  parameter int DEPTH = usd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire usd_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output usd_pkg::cmd_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  usd_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[design/usd_back.sv]
// Back end: expands each command into result transfers via an output register.
`default_nettype none
module usd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire usd_pkg::cmd_t q_head,
  input  wire logic [31:0]   invalid_code,
  input  wire logic          out_stall,
  output logic               q_pop,
  output logic               out_valid,
  output usd_pkg::out_t      out_data
);

  logic          out_valid_r;
  usd_pkg::out_t out_r, out_nxt;
  logic [2:0]    sent_r;          // results already sent from the head
  logic [2:0]    total;
  logic          load;
  logic          last;
  logic          inv;

  assign total     = q_head.n_inv + {2'd0, q_head.has_good};
  assign inv       = (sent_r < q_head.n_inv);
  assign last      = (sent_r + 3'd1 == total);
  assign load      = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop     = load && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Next result from the head command
  always_comb begin
    out_nxt.code_point  = inv ? invalid_code : {11'd0, q_head.cp};
    out_nxt.is_invalid  = inv;
    out_nxt.last_of_run = last;
    out_nxt.text_done   = last && q_head.fin;
  end

  // Output valid and position within the head command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 3'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sent_r      <= last ? 3'd0 : sent_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

[design/utf8_stream_decoder.sv]
// Top level of the UTF-8 stream decoder.
// Path: the first result of a byte goes through the command queue, then the output register.
// Throughput: one byte per cycle while out_stall stays low and each byte gives at most
//   one result; a byte giving k results holds the output side until all k have left,
//   the command queue (QUEUE_DEPTH entries) absorbs such bursts before in_stall rises.
// Reset: synchronous active-low rst_n empties the queue, idles the decoder and
//   sets invalid_code to 0xFFFD; no clearing pass.
`default_nettype none
module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = usd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire usd_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output usd_pkg::out_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [31:0]   cfg_data
);

  logic [31:0]   invalid_code_r;
  logic          q_push, q_pop, q_full, q_empty;
  usd_pkg::cmd_t q_cmd, q_head;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_code_r <= usd_pkg::INVALID_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      invalid_code_r <= cfg_data;
    end
  end

  usd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  usd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  usd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .invalid_code (invalid_code_r),
    .out_stall    (out_stall),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire
